// ===== hdl/urs_pkg.sv =====
// Shared types, constants and helpers for the unbiased random sampler.
// No dependencies; all other files but urs_ram refer to this package by scoped names.
package urs_pkg;

    localparam int MAX_DRAWS_DEF    = 64;
    localparam int SWAP_ENTRIES_DEF = 128;
    localparam int DIV_BITS         = 33;
    localparam int DIV_CNT_W        = $clog2(DIV_BITS + 1);
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 32;

    // Draw modes
    localparam logic [1:0] MODE_SINGLE  = 2'd0;
    localparam logic [1:0] MODE_SORTED  = 2'd1;
    localparam logic [1:0] MODE_ORDERED = 2'd2;
    localparam logic [1:0] MODE_REPLACE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COUNT = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_CUT_WAIT,
        ST_WAIT_BYTE,
        ST_CHECK,
        ST_MOD_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_STORE_J,
        ST_STORE_I,
        ST_RESULT,
        ST_SORT_LD,
        ST_SORT_GETX,
        ST_SORT_CHK,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_OUT_RD,
        ST_OUT_EMIT
    } state_t;

    // Request into the shared remainder unit
    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [DIV_BITS-1:0] divisor;
    } div_req_t;

    // Status back from the remainder unit
    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] rem;
    } div_rsp_t;

    // Fewest bytes whose span covers the limit
    function automatic logic [2:0] byte_width_for(input logic [DIV_BITS-1:0] lim);
        logic [2:0] w;
        if (lim <= 33'd256)
            w = 3'd1;
        else if (lim <= 33'd65536)
            w = 3'd2;
        else if (lim <= 33'd16777216)
            w = 3'd3;
        else
            w = 3'd4;
        return w;
    endfunction

    // 256 raised to the byte width
    function automatic logic [DIV_BITS-1:0] byte_space(input logic [2:0] w);
        logic [DIV_BITS-1:0] s;
        case (w)
            3'd1:    s = 33'h0_0000_0100;
            3'd2:    s = 33'h0_0001_0000;
            3'd3:    s = 33'h0_0100_0000;
            default: s = 33'h1_0000_0000;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/urs_if.sv =====
// Channel interfaces of the unbiased random sampler: input stream, results
// and configuration writes. Depends on urs_pkg for widths.
interface urs_stream_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] random_byte;

    modport source (output valid, kind, random_byte, input ready);
    modport sink   (input valid, kind, random_byte, output ready);
endinterface

interface urs_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, value, last, input ready);
    modport sink   (input valid, value, last, output ready);
endinterface

interface urs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [urs_pkg::CFG_IDX_W-1:0]  index;
    logic [urs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/urs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module urs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/urs_divider.sv =====
// Shared restoring remainder unit, one quotient bit per cycle.
// Depends on urs_pkg for the request and status structs.
module urs_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  urs_pkg::div_req_t req,
    output urs_pkg::div_rsp_t rsp
);

    localparam int N = urs_pkg::DIV_BITS;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [urs_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [N-1:0]                   dvd_reg, dvd_next;
    logic [N-1:0]                   dsr_reg, dsr_next;
    logic [N-1:0]                   rem_reg, rem_next;
    logic [N:0]                     trial;

    // Request load or one shift-subtract step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[N-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = urs_pkg::DIV_CNT_W'(N);
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
                rem_next = N'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[N-1:0];
            dvd_next = {dvd_reg[N-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == urs_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== hdl/unbiased_random_sampler_unit.sv =====
// Top level of the unbiased random sampler: sequencer, swap table and sort.
// Depends on urs_pkg, urs_if, urs_ram and urs_divider.
//
// A start transaction (kind 1) latches the registers and begins a draw set; byte
// transactions (kind 0) feed the random stream big-endian and are dropped when
// no set is running. The stream is ready only while the sequencer waits for a
// byte or is idle. Per draw, one remainder pass on the shared divider sets the
// rejection cutoff, each byte then passes through a wait and a check state,
// and an accepted draw takes another remainder pass for the offset. In the
// distinct modes each draw also scans every filled swap-table entry (up to
// SWAP_ENTRIES of them). The sorted mode ends with an insertion sort and then
// reads the values out. A limit of one or less finishes a draw without bytes,
// so a start may yield results at once.
module unbiased_random_sampler_unit #(
    parameter int MAX_DRAWS    = urs_pkg::MAX_DRAWS_DEF,
    parameter int SWAP_ENTRIES = urs_pkg::SWAP_ENTRIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    urs_stream_if.sink   stream,
    urs_result_if.source result,
    urs_cfg_if.sink      cfg
);

    localparam int CW  = $clog2(MAX_DRAWS + 1);
    localparam int DAW = (MAX_DRAWS > 1) ? $clog2(MAX_DRAWS) : 1;
    localparam int FW  = $clog2(SWAP_ENTRIES + 1);
    localparam int SAW = (SWAP_ENTRIES > 1) ? $clog2(SWAP_ENTRIES) : 1;

    // Configuration registers
    logic [1:0]  mode_reg;
    logic [31:0] range_min_reg;
    logic [31:0] range_max_reg;
    logic [6:0]  draw_count_reg;

    urs_pkg::state_t state_reg, state_next;

    logic [1:0]          mode_set_reg, mode_set_next;
    logic [31:0]         min_set_reg, min_set_next;
    logic [CW-1:0]       total_reg, total_next;
    logic [33:0]         univ_reg, univ_next;
    logic [CW-1:0]       draw_idx_reg, draw_idx_next;
    logic [32:0]         limit_reg, limit_next;
    logic [2:0]          bw_reg, bw_next;
    logic [32:0]         cutoff_reg, cutoff_next;
    logic [31:0]         acc_reg, acc_next;
    logic [2:0]          bt_reg, bt_next;
    logic [31:0]         offset_reg, offset_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [FW-1:0]       scan_reg, scan_next;
    logic                fi_reg, fi_next, fj_reg, fj_next;
    logic [SAW-1:0]      pi_reg, pi_next, pj_reg, pj_next;
    logic [31:0]         vi_fnd_reg, vi_fnd_next, vj_fnd_reg, vj_fnd_next;
    logic [CW-1:0]       sa_reg, sa_next, sb_reg, sb_next;
    logic [31:0]         sx_reg, sx_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_value_reg, out_value_next;
    logic                out_last_reg, out_last_next;

    urs_pkg::div_req_t div_req;
    urs_pkg::div_rsp_t div_rsp;

    logic              sw_we;
    logic [SAW-1:0]    sw_waddr, sw_raddr;
    logic [63:0]       sw_wdata, sw_rdata;
    logic              dv_we;
    logic [DAW-1:0]    dv_waddr, dv_raddr;
    logic [31:0]       dv_wdata, dv_rdata;

    logic        start_acc, byte_acc, slot_free, distinct, lim_le1, last_draw;
    logic [33:0] lim_full;
    logic [2:0]  w_c;
    logic [31:0] i32, j32, vi, vj, val_c;
    logic [8:0]  cnt9;
    logic        table_room;
    urs_pkg::state_t fin_state;

    // Handshake and shared decodes
    assign start_acc  = stream.valid && stream.ready && stream.kind;
    assign byte_acc   = stream.valid && stream.ready && !stream.kind;
    assign slot_free  = !out_valid_reg || result.ready;
    assign distinct   = (mode_set_reg == urs_pkg::MODE_SORTED) ||
                        (mode_set_reg == urs_pkg::MODE_ORDERED);
    assign lim_full   = distinct ? (univ_reg - {{(34-CW){1'b0}}, draw_idx_reg}) : univ_reg;
    assign lim_le1    = lim_full[33] || (lim_full[32:0] <= 33'd1);
    assign w_c        = urs_pkg::byte_width_for(lim_full[32:0]);
    assign i32        = 32'(draw_idx_reg);
    assign j32        = i32 + offset_reg;
    assign vi         = fi_reg ? vi_fnd_reg : i32;
    assign vj         = fj_reg ? vj_fnd_reg : j32;
    assign val_c      = min_set_reg + (distinct ? vj : offset_reg);
    assign last_draw  = (CW'(draw_idx_reg + 1'b1) == total_reg);
    assign table_room = (fill_reg < FW'(SWAP_ENTRIES));
    assign fin_state  = distinct ? urs_pkg::ST_SCAN_RD : urs_pkg::ST_RESULT;
    assign cnt9       = (draw_count_reg == 7'd0) ? 9'd1 : {2'b00, draw_count_reg};

    assign stream.ready = (state_reg == urs_pkg::ST_IDLE) ||
                          (state_reg == urs_pkg::ST_WAIT_BYTE);
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.value = out_value_reg;
    assign result.last  = out_last_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= urs_pkg::MODE_SINGLE;
            range_min_reg  <= '0;
            range_max_reg  <= '0;
            draw_count_reg <= 7'd1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                urs_pkg::REG_MODE:       mode_reg       <= cfg.data[1:0];
                urs_pkg::REG_RANGE_MIN:  range_min_reg  <= cfg.data;
                urs_pkg::REG_RANGE_MAX:  range_max_reg  <= cfg.data;
                urs_pkg::REG_DRAW_COUNT: draw_count_reg <= cfg.data[6:0];
                default:                 mode_reg       <= mode_reg;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            urs_pkg::ST_IDLE:
                if (start_acc)
                    state_next = urs_pkg::ST_PREP;
            urs_pkg::ST_PREP:
                state_next = lim_le1 ? fin_state : urs_pkg::ST_CUT_WAIT;
            urs_pkg::ST_CUT_WAIT:
                if (div_rsp.done)
                    state_next = urs_pkg::ST_WAIT_BYTE;
            urs_pkg::ST_WAIT_BYTE:
                if (start_acc)
                    state_next = urs_pkg::ST_PREP;
                else if (byte_acc)
                    state_next = urs_pkg::ST_CHECK;
            urs_pkg::ST_CHECK:
                if (bt_reg >= bw_reg && {1'b0, acc_reg} < cutoff_reg)
                    state_next = urs_pkg::ST_MOD_WAIT;
                else
                    state_next = urs_pkg::ST_WAIT_BYTE;
            urs_pkg::ST_MOD_WAIT:
                if (div_rsp.done)
                    state_next = fin_state;
            urs_pkg::ST_SCAN_RD:
                state_next = (scan_reg == fill_reg) ? urs_pkg::ST_STORE_J
                                                    : urs_pkg::ST_SCAN_CMP;
            urs_pkg::ST_SCAN_CMP:
                state_next = urs_pkg::ST_SCAN_RD;
            urs_pkg::ST_STORE_J:
                state_next = (i32 == j32) ? urs_pkg::ST_RESULT : urs_pkg::ST_STORE_I;
            urs_pkg::ST_STORE_I:
                state_next = urs_pkg::ST_RESULT;
            urs_pkg::ST_RESULT:
                if (mode_set_reg == urs_pkg::MODE_SORTED || slot_free)
                begin
                    if (!last_draw)
                        state_next = urs_pkg::ST_PREP;
                    else if (mode_set_reg == urs_pkg::MODE_SORTED)
                        state_next = urs_pkg::ST_SORT_LD;
                    else
                        state_next = urs_pkg::ST_IDLE;
                end
            urs_pkg::ST_SORT_LD:
                state_next = (sa_reg >= total_reg) ? urs_pkg::ST_OUT_RD
                                                   : urs_pkg::ST_SORT_GETX;
            urs_pkg::ST_SORT_GETX:
                state_next = urs_pkg::ST_SORT_CHK;
            urs_pkg::ST_SORT_CHK:
                state_next = (sb_reg == '0) ? urs_pkg::ST_SORT_PUT : urs_pkg::ST_SORT_CMP;
            urs_pkg::ST_SORT_CMP:
                state_next = ($signed(dv_rdata) > $signed(sx_reg)) ? urs_pkg::ST_SORT_CHK
                                                                   : urs_pkg::ST_SORT_PUT;
            urs_pkg::ST_SORT_PUT:
                state_next = urs_pkg::ST_SORT_LD;
            urs_pkg::ST_OUT_RD:
                state_next = urs_pkg::ST_OUT_EMIT;
            urs_pkg::ST_OUT_EMIT:
                if (slot_free)
                    state_next = (CW'(sa_reg + 1'b1) >= total_reg) ? urs_pkg::ST_IDLE
                                                                   : urs_pkg::ST_OUT_RD;
            default:
                state_next = urs_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates and memory / divider controls
    always_comb
    begin
        mode_set_next  = mode_set_reg;
        min_set_next   = min_set_reg;
        total_next     = total_reg;
        univ_next      = univ_reg;
        draw_idx_next  = draw_idx_reg;
        limit_next     = limit_reg;
        bw_next        = bw_reg;
        cutoff_next    = cutoff_reg;
        acc_next       = acc_reg;
        bt_next        = bt_reg;
        offset_next    = offset_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        fi_next        = fi_reg;
        fj_next        = fj_reg;
        pi_next        = pi_reg;
        pj_next        = pj_reg;
        vi_fnd_next    = vi_fnd_reg;
        vj_fnd_next    = vj_fnd_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        sx_next        = sx_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        div_req        = '0;
        sw_we          = 1'b0;
        sw_waddr       = '0;
        sw_wdata       = '0;
        sw_raddr       = scan_reg[SAW-1:0];
        dv_we          = 1'b0;
        dv_waddr       = '0;
        dv_wdata       = '0;
        dv_raddr       = sa_reg[DAW-1:0];

        // New draw set: latch registers, clear the swap table
        if (start_acc)
        begin
            mode_set_next = mode_reg;
            min_set_next  = range_min_reg;
            if (mode_reg == urs_pkg::MODE_SINGLE)
                total_next = CW'(1);
            else if (cnt9 > 9'(MAX_DRAWS))
                total_next = CW'(MAX_DRAWS);
            else
                total_next = CW'(cnt9);
            univ_next     = {{2{range_max_reg[31]}}, range_max_reg} -
                            {{2{range_min_reg[31]}}, range_min_reg} + 34'd1;
            draw_idx_next = '0;
            fill_next     = '0;
        end

        case (state_reg)
            urs_pkg::ST_PREP:
            begin
                limit_next  = lim_full[32:0];
                bw_next     = w_c;
                acc_next    = '0;
                bt_next     = '0;
                offset_next = '0;
                scan_next   = '0;
                fi_next     = 1'b0;
                fj_next     = 1'b0;
                if (!lim_le1)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = urs_pkg::byte_space(w_c);
                    div_req.divisor  = lim_full[32:0];
                end
            end
            urs_pkg::ST_CUT_WAIT:
                if (div_rsp.done)
                    cutoff_next = urs_pkg::byte_space(bw_reg) - div_rsp.rem;
            urs_pkg::ST_WAIT_BYTE:
                if (byte_acc)
                begin
                    acc_next = {acc_reg[23:0], stream.random_byte};
                    bt_next  = bt_reg + 3'd1;
                end
            urs_pkg::ST_CHECK:
                if (bt_reg >= bw_reg)
                begin
                    if ({1'b0, acc_reg} < cutoff_reg)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {1'b0, acc_reg};
                        div_req.divisor  = limit_reg;
                    end
                    else
                    begin
                        acc_next = '0;
                        bt_next  = '0;
                    end
                end
            urs_pkg::ST_MOD_WAIT:
                if (div_rsp.done)
                    offset_next = div_rsp.rem[31:0];
            urs_pkg::ST_SCAN_CMP:
            begin
                if (sw_rdata[63:32] == j32 && !fj_reg)
                begin
                    fj_next     = 1'b1;
                    pj_next     = scan_reg[SAW-1:0];
                    vj_fnd_next = sw_rdata[31:0];
                end
                if (sw_rdata[63:32] == i32 && !fi_reg)
                begin
                    fi_next     = 1'b1;
                    pi_next     = scan_reg[SAW-1:0];
                    vi_fnd_next = sw_rdata[31:0];
                end
                scan_next = scan_reg + 1'b1;
            end
            urs_pkg::ST_STORE_J:
            begin
                sw_wdata = {j32, vi};
                if (fj_reg)
                begin
                    sw_we    = 1'b1;
                    sw_waddr = pj_reg;
                end
                else if (table_room)
                begin
                    sw_we     = 1'b1;
                    sw_waddr  = fill_reg[SAW-1:0];
                    fill_next = fill_reg + 1'b1;
                end
            end
            urs_pkg::ST_STORE_I:
            begin
                sw_wdata = {i32, vj};
                if (fi_reg)
                begin
                    sw_we    = 1'b1;
                    sw_waddr = pi_reg;
                end
                else if (table_room)
                begin
                    sw_we     = 1'b1;
                    sw_waddr  = fill_reg[SAW-1:0];
                    fill_next = fill_reg + 1'b1;
                end
            end
            urs_pkg::ST_RESULT:
                if (mode_set_reg == urs_pkg::MODE_SORTED || slot_free)
                begin
                    if (mode_set_reg == urs_pkg::MODE_SORTED)
                    begin
                        dv_we    = 1'b1;
                        dv_waddr = draw_idx_reg[DAW-1:0];
                        dv_wdata = val_c;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = val_c;
                        out_last_next  = last_draw;
                    end
                    draw_idx_next = draw_idx_reg + 1'b1;
                    sa_next       = CW'(1);
                end
            urs_pkg::ST_SORT_LD:
                if (sa_reg >= total_reg)
                    sa_next = '0;
            urs_pkg::ST_SORT_GETX:
            begin
                sx_next = dv_rdata;
                sb_next = sa_reg;
            end
            urs_pkg::ST_SORT_CHK:
                dv_raddr = DAW'(sb_reg - 1'b1);
            urs_pkg::ST_SORT_CMP:
                if ($signed(dv_rdata) > $signed(sx_reg))
                begin
                    dv_we    = 1'b1;
                    dv_waddr = sb_reg[DAW-1:0];
                    dv_wdata = dv_rdata;
                    sb_next  = sb_reg - 1'b1;
                end
            urs_pkg::ST_SORT_PUT:
            begin
                dv_we    = 1'b1;
                dv_waddr = sb_reg[DAW-1:0];
                dv_wdata = sx_reg;
                sa_next  = sa_reg + 1'b1;
            end
            urs_pkg::ST_OUT_EMIT:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = dv_rdata;
                    out_last_next  = (CW'(sa_reg + 1'b1) == total_reg);
                    sa_next        = sa_reg + 1'b1;
                end
            default:
                sa_next = sa_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= urs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            draw_idx_reg  <= '0;
            fill_reg      <= '0;
            total_reg     <= CW'(1);
            mode_set_reg  <= urs_pkg::MODE_SINGLE;
            bt_reg        <= '0;
            bw_reg        <= '0;
            cutoff_reg    <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            draw_idx_reg  <= draw_idx_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            mode_set_reg  <= mode_set_next;
            bt_reg        <= bt_next;
            bw_reg        <= bw_next;
            cutoff_reg    <= cutoff_next;
            acc_reg       <= acc_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        min_set_reg   <= min_set_next;
        univ_reg      <= univ_next;
        limit_reg     <= limit_next;
        offset_reg    <= offset_next;
        scan_reg      <= scan_next;
        fi_reg        <= fi_next;
        fj_reg        <= fj_next;
        pi_reg        <= pi_next;
        pj_reg        <= pj_next;
        vi_fnd_reg    <= vi_fnd_next;
        vj_fnd_reg    <= vj_fnd_next;
        sa_reg        <= sa_next;
        sb_reg        <= sb_next;
        sx_reg        <= sx_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    urs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Swap table: key in the upper word, value in the lower
    urs_ram #(
        .WIDTH (64),
        .DEPTH (SWAP_ENTRIES)
    ) u_swap_ram (
        .clk   (clk),
        .we    (sw_we),
        .waddr (sw_waddr),
        .wdata (sw_wdata),
        .raddr (sw_raddr),
        .rdata (sw_rdata)
    );

    // Values held for the sorted mode
    urs_ram #(
        .WIDTH (32),
        .DEPTH (MAX_DRAWS)
    ) u_drawn_ram (
        .clk   (clk),
        .we    (dv_we),
        .waddr (dv_waddr),
        .wdata (dv_wdata),
        .raddr (dv_raddr),
        .rdata (dv_rdata)
    );

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(SWAP_ENTRIES))
        else $error("swap table fill count overran its depth");

    a_cutoff_set: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == urs_pkg::ST_WAIT_BYTE |-> cutoff_reg != '0)
        else $error("waiting for bytes with no rejection cutoff");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start_acc |=> fill_reg == '0 && draw_idx_reg == '0)
        else $error("start did not clear the set state");

    a_draw_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == urs_pkg::ST_RESULT |-> draw_idx_reg < total_reg)
        else $error("draw index beyond the set size");

endmodule

// ===== bench/tb_unbiased_random_sampler_unit.sv =====
`timescale 1ns / 1ps
// Testbench of unbiased_random_sampler_unit: random-byte and start transactions
// go in, drawn values are checked against an in-bench model of the sampler.
// Depends on urs_pkg, the urs_* interfaces and the RTL of the block.
module tb_unbiased_random_sampler_unit;

    localparam int NUM_DRAWS   = 64;
    localparam int NUM_SWAP    = 128;
    localparam int SETTLE_CYC  = 600;
    localparam int STALL_LIMIT = 40000;
    localparam bit KIND_BYTE   = 1'b0;
    localparam bit KIND_START  = 1'b1;

    typedef struct {
        bit       kind;
        bit [7:0] rbyte;
    } stream_item_t;

    typedef struct {
        logic [31:0] value;
        bit          last;
    } draw_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Locally held drive values, known from time zero
    logic        s_valid = 1'b0;
    logic        s_kind = 1'b0;
    logic [7:0]  s_byte = 8'd0;
    logic        r_ready = 1'b0;
    logic        c_valid = 1'b0;
    logic [urs_pkg::CFG_IDX_W-1:0]  c_index = '0;
    logic [urs_pkg::CFG_DATA_W-1:0] c_data = '0;

    urs_stream_if strm();
    urs_result_if res();
    urs_cfg_if    cfg();

    assign strm.valid       = s_valid;
    assign strm.kind        = s_kind;
    assign strm.random_byte = s_byte;
    assign res.ready        = r_ready;
    assign cfg.valid        = c_valid;
    assign cfg.index        = c_index;
    assign cfg.data         = c_data;

    unbiased_random_sampler_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (strm.sink),
        .result (res.source),
        .cfg    (cfg.sink)
    );

    always #10 clk = ~clk;

    stream_item_t pending_items[$];
    draw_t        expected_draws[$];
    int           error_count = 0;
    int           idle_pct = 32;

    // Sampler model: registers, latched set and draw state
    logic [1:0]  reg_mode = urs_pkg::MODE_SINGLE;
    logic [31:0] reg_min = '0;
    logic [31:0] reg_max = '0;
    logic [6:0]  reg_count = 7'd1;

    logic [1:0]  set_mode = urs_pkg::MODE_SINGLE;
    logic [31:0] set_min = '0;
    int          set_total = 1;
    longint      set_universe = 1;
    longint      cur_limit = 1;
    bit          busy = 1'b0;
    int          draw_idx = 0;
    logic [31:0] acc = '0;
    int          taken = 0;
    int          width = 0;
    longint      cutoff = 0;
    int          emitted = 0;
    logic [31:0] swap_key [NUM_SWAP];
    logic [31:0] swap_val [NUM_SWAP];
    bit          swap_used [NUM_SWAP];
    logic [31:0] held_vals [NUM_DRAWS];

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void push_draw(input logic [31:0] v, input bit l);
        draw_t d;
        if (emitted >= NUM_DRAWS)
            return;
        d.value = v;
        d.last  = l;
        expected_draws.insert(expected_draws.size(), d);
        emitted++;
    endfunction

    function automatic logic [31:0] swap_read(input logic [31:0] key);
        for (int e = 0; e < NUM_SWAP; e++)
            if (swap_used[e] && swap_key[e] == key)
                return swap_val[e];
        return key;
    endfunction

    function automatic void swap_write(input logic [31:0] key, input logic [31:0] v);
        for (int e = 0; e < NUM_SWAP; e++)
            if (swap_used[e] && swap_key[e] == key)
            begin
                swap_val[e] = v;
                return;
            end
        for (int e = 0; e < NUM_SWAP; e++)
            if (!swap_used[e])
            begin
                swap_used[e] = 1'b1;
                swap_key[e]  = key;
                swap_val[e]  = v;
                return;
            end
    endfunction

    function automatic void finish_draw(input longint offset);
        logic [31:0] v, i, j, vi, vj, x;
        int b;
        if (set_mode == urs_pkg::MODE_SORTED || set_mode == urs_pkg::MODE_ORDERED)
        begin
            i  = 32'(draw_idx);
            j  = i + offset[31:0];
            vj = swap_read(j);
            vi = swap_read(i);
            swap_write(j, vi);
            swap_write(i, vj);
            v = set_min + vj;
        end
        else
            v = set_min + offset[31:0];
        if (set_mode == urs_pkg::MODE_SORTED)
            held_vals[draw_idx % NUM_DRAWS] = v;
        else
            push_draw(v, draw_idx + 1 == set_total);
        draw_idx++;
        if (draw_idx >= set_total)
        begin
            busy = 1'b0;
            if (set_mode == urs_pkg::MODE_SORTED)
            begin
                // insertion sort on signed values
                for (int a = 1; a < set_total; a++)
                begin
                    x = held_vals[a];
                    b = a;
                    while (b > 0 && $signed(held_vals[b-1]) > $signed(x))
                    begin
                        held_vals[b] = held_vals[b-1];
                        b--;
                    end
                    held_vals[b] = x;
                end
                for (int a = 0; a < set_total; a++)
                    push_draw(held_vals[a], a + 1 == set_total);
            end
        end
    endfunction

    // Set up the next draw, finishing draws whose limit needs no bytes
    function automatic void next_draw();
        longint span;
        while (busy)
        begin
            span = 256;
            if (set_mode == urs_pkg::MODE_SORTED || set_mode == urs_pkg::MODE_ORDERED)
                cur_limit = set_universe - draw_idx;
            else
                cur_limit = set_universe;
            if (cur_limit <= 1)
            begin
                finish_draw(0);
                continue;
            end
            width = 1;
            while (span < cur_limit)
            begin
                width++;
                span = span * 256;
            end
            cutoff = (span / cur_limit) * cur_limit;
            acc    = '0;
            taken  = 0;
            return;
        end
    endfunction

    function automatic void predict_draws(input stream_item_t it);
        int cnt;
        emitted = 0;
        if (it.kind == KIND_START)
        begin
            cnt = (reg_count == 0) ? 1 : reg_count;
            if (cnt > NUM_DRAWS)
                cnt = NUM_DRAWS;
            set_mode     = reg_mode;
            set_min      = reg_min;
            set_total    = (reg_mode == urs_pkg::MODE_SINGLE) ? 1 : cnt;
            set_universe = longint'($signed(reg_max)) - longint'($signed(reg_min)) + 1;
            for (int e = 0; e < NUM_SWAP; e++)
                swap_used[e] = 1'b0;
            draw_idx = 0;
            busy     = 1'b1;
            next_draw();
            return;
        end
        if (!busy)
            return;
        acc = {acc[23:0], it.rbyte};
        taken++;
        if (taken >= width)
        begin
            if (longint'({1'b0, acc}) < cutoff)
            begin
                finish_draw(longint'({1'b0, acc}) % cur_limit);
                next_draw();
            end
            else
            begin
                acc   = '0;
                taken = 0;
            end
        end
    endfunction

    // Stream driver: feeds pending items, predicts each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid <= 1'b0;
        else
        begin
            if (s_valid && strm.ready)
            begin
                predict_draws(pending_items.pop_front());
            end
            if (!s_valid || strm.ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    s_valid <= 1'b1;
                    s_kind  <= pending_items[0].kind;
                    s_byte  <= pending_items[0].rbyte;
                end
                else
                    s_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        draw_t d;
        if (!rst_n)
            r_ready <= 1'b0;
        else
        begin
            if (res.valid && r_ready)
            begin
                if (expected_draws.size() == 0)
                    report($sformatf("unexpected value %0d", $signed(res.value)));
                else
                begin
                    d = expected_draws.pop_front();
                    if (res.value !== d.value)
                        report($sformatf("value %0d, want %0d",
                               $signed(res.value), $signed(d.value)));
                    if (res.last !== d.last)
                        report($sformatf("last %b, want %b", res.last, d.last));
                end
            end
            r_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog on cycles with no transaction
    int stall_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_valid && strm.ready) || (res.valid && r_ready) || (c_valid && cfg.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [urs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] v);
        @(posedge clk);
        c_valid <= 1'b1;
        c_index <= idx;
        c_data  <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            urs_pkg::REG_MODE:       reg_mode  = v[1:0];
            urs_pkg::REG_RANGE_MIN:  reg_min   = v;
            urs_pkg::REG_RANGE_MAX:  reg_max   = v;
            urs_pkg::REG_DRAW_COUNT: reg_count = v[6:0];
            default: ;
        endcase
        c_valid <= 1'b0;
    endtask

    task automatic setup(input logic [1:0] m, input logic [31:0] lo,
                         input logic [31:0] hi, input logic [6:0] cnt);
        write_reg(urs_pkg::REG_MODE, 32'(m));
        write_reg(urs_pkg::REG_RANGE_MIN, lo);
        write_reg(urs_pkg::REG_RANGE_MAX, hi);
        write_reg(urs_pkg::REG_DRAW_COUNT, 32'(cnt));
    endtask

    task automatic push_item(input bit k, input bit [7:0] b);
        stream_item_t it;
        it.kind  = k;
        it.rbyte = b;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_random_set(input int n_bytes);
        push_item(KIND_START, 8'($urandom));
        for (int k = 0; k < n_bytes; k++)
            push_item(KIND_BYTE, 8'($urandom));
    endtask

    // Wait for all traffic to drain, then let the block settle
    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_draws.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    initial
    begin
        logic [1:0]  m;
        logic [31:0] lo, span;
        logic [6:0]  cnt;
        int          nb;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Defaults: single-value range gives range_min at once; idle byte ignored
        push_item(KIND_BYTE, 8'h5A);
        push_item(KIND_START, 8'h00);
        push_item(KIND_BYTE, 8'hA5);
        drain();

        // Full 32-bit range, extreme byte patterns
        setup(urs_pkg::MODE_SINGLE, 32'h8000_0000, 32'h7FFF_FFFF, 7'd5);
        push_item(KIND_START, 8'h00);
        repeat (4) push_item(KIND_BYTE, 8'h00);
        push_item(KIND_START, 8'h00);
        repeat (4) push_item(KIND_BYTE, 8'hFF);
        drain();

        // Sorted distinct, limit 200: top bytes are rejected
        setup(urs_pkg::MODE_SORTED, 32'd10, 32'd209, 7'd3);
        push_item(KIND_START, 8'h00);
        push_item(KIND_BYTE, 8'hFF);
        push_item(KIND_BYTE, 8'hC8);
        push_item(KIND_BYTE, 8'h07);
        push_item(KIND_BYTE, 8'h80);
        push_item(KIND_BYTE, 8'h00);
        drain();

        // Draw order with range smaller than count; no bytes needed at the tail
        setup(urs_pkg::MODE_ORDERED, 32'hFFFF_FFFD, 32'd2, 7'd10);
        push_item(KIND_START, 8'h00);
        repeat (6) push_item(KIND_BYTE, 8'h33);
        drain();

        // Inverted range, zero count; then saturated count with replacement
        setup(urs_pkg::MODE_REPLACE, 32'd5, 32'd4, 7'd0);
        push_item(KIND_START, 8'h00);
        drain();
        idle_pct = 0;
        setup(urs_pkg::MODE_REPLACE, 32'h7FFF_FFFF, 32'h8000_0000, 7'd127);
        push_item(KIND_START, 8'h00);
        drain();
        setup(urs_pkg::MODE_REPLACE, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 7'd127);
        push_random_set(70);
        drain();
        idle_pct = 32;

        // Random phases: mostly small ranges and counts, a few large ones
        for (int p = 0; p < 6; p++)
        begin
            m   = 2'($urandom_range(3));
            lo  = $urandom;
            case ($urandom_range(3))
                0:       span = $urandom;
                1:       span = $urandom_range(70000);
                default: span = $urandom_range(300);
            endcase
            cnt = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(6));
            setup(m, lo, lo + span, cnt);
            nb = (cnt > 8) ? 8 : cnt + 1;
            push_random_set(nb * 2 + $urandom_range(3));
            drain();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== unbiased_random_sampler_unit.f =====
hdl/urs_pkg.sv
hdl/urs_if.sv
hdl/urs_ram.sv
hdl/urs_divider.sv
hdl/unbiased_random_sampler_unit.sv
bench/tb_unbiased_random_sampler_unit.sv
